// ===== sv/brof_pkg.sv =====
// ============================================================================
// brof_pkg: shared types and codes for the bitmap range/find block
// Command and response item layouts, command modes, word unit op codes and
// the word unit status group.
// ============================================================================
package brof_pkg;

    // Field widths of the command and response items
    localparam int MODE_W = 3;
    localparam int IDX_W  = 11;
    localparam int FIDX_W = 10;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_SET_RANGE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR_RANGE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FLIP_RANGE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ_BIT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NEXT_SET    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NEXT_CLEAR  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CLEAR_ALL   = 3'd6;

    // Word unit operations
    typedef logic [2:0] op_t;
    localparam op_t OP_SET1  = 3'd0;
    localparam op_t OP_CLR   = 3'd1;
    localparam op_t OP_FLIP  = 3'd2;
    localparam op_t OP_FIND1 = 3'd3;
    localparam op_t OP_FIND0 = 3'd4;

    // Command item
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  from_index;
        logic [IDX_W-1:0]  to_index;
        logic              value;
    } cmd_t;

    // Response item
    typedef struct packed {
        logic              status;
        logic              bit_value;
        logic              found;
        logic [FIDX_W-1:0] found_index;
        logic [IDX_W-1:0]  current_length;
        logic              all_clear;
    } rsp_t;

    // Word unit status back to the sequencer
    typedef struct packed {
        logic write;   // op modifies the word
        logic found;   // find op hit a matching bit in the window
        logic old_nz;  // word had a set bit before
        logic new_nz;  // word has a set bit after
    } unit_stat_t;

endpackage

// ===== sv/brof_store.sv =====
// ============================================================================
// brof_store: bitmap word memory
// One write port and one read port, registered read data, no reset.
// ============================================================================
module brof_store #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/brof_word_split.sv =====
// ============================================================================
// brof_word_split: bit index to word index and bit offset
// Two-stage divide by the word width using a reciprocal multiply, with a
// single correction step on the output side.
// ============================================================================
module brof_word_split #(
    parameter int XW         = 11,
    parameter int WORD_WIDTH = 32,
    parameter int OW         = 5
) (
    input  logic          clk,
    input  logic [XW-1:0] x,
    output logic [XW-1:0] q,
    output logic [OW-1:0] r
);

    localparam int PW = 2 * XW;
    localparam logic [XW-1:0] RECIP = XW'((2 ** XW) / WORD_WIDTH);

    logic [PW-1:0] prod_reg;
    logic [XW-1:0] x1_reg;
    logic [XW-1:0] q_est_reg;
    logic [XW-1:0] r_est_reg;
    logic [XW-1:0] q_est;
    logic          r_big;

    // Stage 1: x * floor(2^XW / W)
    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(x) * PW'(RECIP);
        x1_reg   <= x;
    end

    // Stage 2: estimate is exact or one low
    assign q_est = prod_reg[PW-1:XW];

    always_ff @(posedge clk)
    begin
        q_est_reg <= q_est;
        r_est_reg <= x1_reg - q_est * XW'(WORD_WIDTH);
    end

    // Correction
    assign r_big = (r_est_reg >= XW'(WORD_WIDTH));
    assign q     = r_big ? (q_est_reg + XW'(1)) : q_est_reg;
    assign r     = r_big ? OW'(r_est_reg - XW'(WORD_WIDTH)) : OW'(r_est_reg);

endmodule

// ===== sv/brof_word_unit.sv =====
// ============================================================================
// brof_word_unit: shared word operation unit
// Builds the bit window of one word from the scan bounds, then sets, clears
// or flips it, or finds the lowest matching bit inside it.
// ============================================================================
module brof_word_unit
    import brof_pkg::*;
#(
    parameter int CW         = 11,
    parameter int WORD_WIDTH = 32,
    parameter int OW         = 5,
    parameter int HW         = 6
) (
    input  logic [WORD_WIDTH-1:0] word,
    input  logic [CW-1:0]         base,
    input  logic [CW-1:0]         start,
    input  logic [CW-1:0]         stop,
    input  op_t                   op,
    output logic [WORD_WIDTH-1:0] new_word,
    output logic [OW-1:0]         fpos,
    output unit_stat_t            stat
);

    logic [CW-1:0]         lo_diff;
    logic [CW-1:0]         hi_diff;
    logic [HW-1:0]         lo;
    logic [HW-1:0]         hi;
    logic [WORD_WIDTH-1:0] mask;
    logic [WORD_WIDTH-1:0] target;
    logic [WORD_WIDTH-1:0] lowest;

    // Window bounds relative to this word
    assign lo_diff = start - base;
    assign hi_diff = stop - base;
    assign lo = (start > base) ? lo_diff[HW-1:0] : '0;
    assign hi = (hi_diff >= CW'(WORD_WIDTH)) ? HW'(WORD_WIDTH) : hi_diff[HW-1:0];

    always_comb
    begin
        for (int i = 0; i < WORD_WIDTH; i++)
        begin
            mask[i] = (HW'(i) >= lo) && (HW'(i) < hi);
        end
    end

    // Word update, search target and status
    always_comb
    begin
        new_word   = word;
        target     = '0;
        stat.write = 1'b0;
        case (op)
            OP_SET1:
            begin
                new_word   = word | mask;
                stat.write = 1'b1;
            end
            OP_CLR:
            begin
                new_word   = word & ~mask;
                stat.write = 1'b1;
            end
            OP_FLIP:
            begin
                new_word   = word ^ mask;
                stat.write = 1'b1;
            end
            OP_FIND1:
            begin
                target = word & mask;
            end
            OP_FIND0:
            begin
                target = ~word & mask;
            end
            default:
            begin
                new_word = word;
            end
        endcase
        stat.found  = |target;
        stat.old_nz = |word;
        stat.new_nz = |new_word;
    end

    // Lowest matching bit: isolate, then encode
    assign lowest = target & (~target + WORD_WIDTH'(1));

    always_comb
    begin
        fpos = '0;
        for (int i = 0; i < WORD_WIDTH; i++)
        begin
            for (int b = 0; b < OW; b++)
            begin
                if (((i >> b) & 1) == 1)
                begin
                    fpos[b] = fpos[b] | lowest[i];
                end
            end
        end
    end

endmodule

// ===== sv/bitmap_range_ops_find_next.sv =====
// ============================================================================
// bitmap_range_ops_find_next: bitmap with range commands and bit search
// Word-serial sequencer over a word memory with one shared word unit.
// ============================================================================
// Flow: after acceptance, setup states S_DIV1 and S_DIV2 (two-stage word split) and S_DIV3
//   (bounds check), then the word scan in S_SCAN and the response load in S_DONE. A rejected
//   or empty range command goes straight to S_DONE, and an empty scan ends at S_DIV3.
// Commands: one at a time; cmd_stall stays high until the response is loaded.
//   Searches stop early.
// Reset: length 0; a clearing pass stalls commands while it runs, and a
//   length write runs a trim pass over the words above the new length.
module bitmap_range_ops_find_next
    import brof_pkg::*;
#(
    parameter int CAPACITY   = 1024,
    parameter int WORD_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  cmd_t             cmd,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_wr_data
);

    localparam int NW  = (CAPACITY + WORD_WIDTH - 1) / WORD_WIDTH;
    localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int XW  = $clog2(CAPACITY + 1);
    localparam int CW  = (XW > IDX_W) ? XW : IDX_W;
    localparam int BW  = CW + 1;
    localparam int OW  = $clog2(WORD_WIDTH);
    localparam int HW  = $clog2(WORD_WIDTH + 1);
    localparam int NCW = $clog2(NW + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_DIV2 = 3'd2;
    localparam logic [2:0] S_DIV3 = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]        state_reg, state_next;
    op_t               op_reg, op_next;
    logic [CW-1:0]     start_reg, start_next;
    logic [CW-1:0]     end_reg, end_next;
    logic              noctr_reg, noctr_next;
    logic              res_pend_reg, res_pend_next;
    logic              read_reg, read_next;
    logic              res_status_reg, res_status_next;
    logic              res_found_reg, res_found_next;
    logic [FIDX_W-1:0] res_fidx_reg, res_fidx_next;
    logic [XW-1:0]     length_reg, length_next;
    logic [NCW-1:0]    nz_reg, nz_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic [BW-1:0]     rd_base_reg, rd_base_next;
    logic              iss_more_reg, iss_more_next;
    logic              dv_reg, dv_next;
    logic [AW-1:0]     d_addr_reg, d_addr_next;
    logic [CW-1:0]     d_base_reg, d_base_next;
    logic              d_last_reg, d_last_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic [CW-1:0]         cmd_from;
    logic [CW-1:0]         cmd_to;
    logic [CW-1:0]         len_cw;
    logic [CW-1:0]         cap_cw;
    logic [CW-1:0]         cfg_raw;
    logic [CW-1:0]         cfg_len;
    logic [CW-1:0]         read_end;
    logic [CW-1:0]         split_q;
    logic [OW-1:0]         split_r;
    logic                  mem_re;
    logic                  mem_we;
    logic [WORD_WIDTH-1:0] mem_rdata;
    logic [WORD_WIDTH-1:0] unit_word;
    logic [OW-1:0]         unit_fpos;
    unit_stat_t            unit_stat;
    logic                  finish;

    // Operand views at internal width
    assign cmd_from = CW'(cmd.from_index);
    assign cmd_to   = CW'(cmd.to_index);
    assign len_cw   = CW'(length_reg);
    assign cap_cw   = CW'(CAPACITY);
    assign cfg_raw  = CW'(cfg_wr_data);
    assign cfg_len  = (cfg_raw > cap_cw) ? cap_cw : cfg_raw;
    assign read_end = (cmd_from < len_cw) ? (cmd_from + CW'(1)) : len_cw;

    assign cmd_stall = (state_reg != S_IDLE) || cfg_wr_en;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Word index and offset of the scan start
    brof_word_split #(
        .XW         (CW),
        .WORD_WIDTH (WORD_WIDTH),
        .OW         (OW)
    ) u_split (
        .clk (clk),
        .x   (start_reg),
        .q   (split_q),
        .r   (split_r)
    );

    // Word memory
    brof_store #(
        .DEPTH (NW),
        .WIDTH (WORD_WIDTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .rd_en   (mem_re),
        .rd_addr (rd_addr_reg),
        .rd_data (mem_rdata),
        .wr_en   (mem_we),
        .wr_addr (d_addr_reg),
        .wr_data (unit_word)
    );

    // Shared word unit on the read data
    brof_word_unit #(
        .CW         (CW),
        .WORD_WIDTH (WORD_WIDTH),
        .OW         (OW),
        .HW         (HW)
    ) u_unit (
        .word     (mem_rdata),
        .base     (d_base_reg),
        .start    (start_reg),
        .stop     (end_reg),
        .op       (op_reg),
        .new_word (unit_word),
        .fpos     (unit_fpos),
        .stat     (unit_stat)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        noctr_next      = noctr_reg;
        res_pend_next   = res_pend_reg;
        read_next       = read_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_fidx_next   = res_fidx_reg;
        length_next     = length_reg;
        nz_next         = nz_reg;
        rd_addr_next    = rd_addr_reg;
        rd_base_next    = rd_base_reg;
        iss_more_next   = iss_more_reg;
        dv_next         = dv_reg;
        d_addr_next     = d_addr_reg;
        d_base_next     = d_base_reg;
        d_last_next     = d_last_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        finish          = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !cmd_stall)
                begin
                    res_pend_next   = 1'b1;
                    res_status_next = 1'b0;
                    res_found_next  = 1'b0;
                    res_fidx_next   = '0;
                    read_next       = 1'b0;
                    noctr_next      = 1'b0;
                    state_next      = S_DONE;
                    case (cmd.mode)
                        MODE_SET_RANGE, MODE_CLEAR_RANGE, MODE_FLIP_RANGE:
                        begin
                            if ((cmd_from > cmd_to) || (cmd_to > cap_cw))
                            begin
                                res_status_next = 1'b1;
                            end
                            else if (cmd_from != cmd_to)
                            begin
                                start_next = cmd_from;
                                end_next   = cmd_to;
                                state_next = S_DIV1;
                                if (cmd.mode == MODE_SET_RANGE)
                                begin
                                    op_next = cmd.value ? OP_SET1 : OP_CLR;
                                end
                                else if (cmd.mode == MODE_FLIP_RANGE)
                                begin
                                    op_next = OP_FLIP;
                                end
                                else
                                begin
                                    op_next = OP_CLR;
                                end
                                // set and flip extend the length
                                if ((cmd.mode != MODE_CLEAR_RANGE) && (cmd_to > len_cw))
                                begin
                                    length_next = XW'(cmd_to);
                                end
                            end
                        end
                        MODE_READ_BIT:
                        begin
                            if (cmd_from >= cap_cw)
                            begin
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                op_next    = OP_FIND1;
                                start_next = cmd_from;
                                end_next   = read_end;
                                read_next  = 1'b1;
                                state_next = S_DIV1;
                            end
                        end
                        MODE_NEXT_SET, MODE_NEXT_CLEAR:
                        begin
                            if (cmd_from >= cap_cw)
                            begin
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                op_next    = (cmd.mode == MODE_NEXT_SET) ? OP_FIND1 : OP_FIND0;
                                start_next = cmd_from;
                                end_next   = len_cw;
                                state_next = S_DIV1;
                            end
                        end
                        MODE_CLEAR_ALL:
                        begin
                            op_next    = OP_CLR;
                            start_next = '0;
                            end_next   = cap_cw;
                            noctr_next = 1'b1;
                            nz_next    = '0;
                            state_next = S_DIV1;
                        end
                        default:
                        begin
                            res_status_next = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV1:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                state_next = S_DIV3;
            end
            S_DIV3:
            begin
                if (start_reg >= end_reg)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    rd_addr_next  = split_q[AW-1:0];
                    rd_base_next  = {1'b0, start_reg} - BW'(split_r);
                    iss_more_next = 1'b1;
                    dv_next       = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // read issue side
                dv_next = 1'b0;
                if (iss_more_reg)
                begin
                    mem_re        = 1'b1;
                    dv_next       = 1'b1;
                    d_addr_next   = rd_addr_reg;
                    d_base_next   = rd_base_reg[CW-1:0];
                    d_last_next   = (rd_base_reg + BW'(WORD_WIDTH)) >= {1'b0, end_reg};
                    iss_more_next = !d_last_next;
                    rd_addr_next  = rd_addr_reg + AW'(1);
                    rd_base_next  = rd_base_reg + BW'(WORD_WIDTH);
                end
                // data side
                if (dv_reg)
                begin
                    if (unit_stat.write)
                    begin
                        mem_we = 1'b1;
                        if (!noctr_reg)
                        begin
                            if (unit_stat.new_nz && !unit_stat.old_nz)
                            begin
                                nz_next = nz_reg + NCW'(1);
                            end
                            else if (!unit_stat.new_nz && unit_stat.old_nz)
                            begin
                                nz_next = nz_reg - NCW'(1);
                            end
                        end
                    end
                    if (!unit_stat.write && unit_stat.found)
                    begin
                        res_found_next = 1'b1;
                        res_fidx_next  = FIDX_W'(d_base_reg + CW'(unit_fpos));
                        finish         = 1'b1;
                    end
                    else if (d_last_reg)
                    begin
                        finish = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.status         = res_status_reg;
                    rsp_next.bit_value      = read_reg & res_found_reg;
                    rsp_next.found          = !read_reg & res_found_reg;
                    rsp_next.found_index    = read_reg ? '0 : res_fidx_reg;
                    rsp_next.current_length = IDX_W'(length_reg);
                    rsp_next.all_clear      = (nz_reg == '0);
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // End of scan: respond or go quiet
        if (finish)
        begin
            state_next    = res_pend_reg ? S_DONE : S_IDLE;
            dv_next       = 1'b0;
            iss_more_next = 1'b0;
        end

        // Length write: load, then trim everything above it
        if (cfg_wr_en)
        begin
            length_next   = XW'(cfg_len);
            start_next    = ((state_reg != S_IDLE) && (start_reg < cfg_len)) ? start_reg : cfg_len;
            end_next      = cap_cw;
            op_next       = OP_CLR;
            noctr_next    = (state_reg != S_IDLE) ? noctr_reg : 1'b0;
            res_pend_next = 1'b0;
            dv_next       = 1'b0;
            iss_more_next = 1'b0;
            state_next    = S_DIV1;
        end
    end

    // Control registers; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_DIV1;
            op_reg         <= OP_CLR;
            start_reg      <= '0;
            end_reg        <= CW'(CAPACITY);
            noctr_reg      <= 1'b1;
            res_pend_reg   <= 1'b0;
            read_reg       <= 1'b0;
            length_reg     <= '0;
            nz_reg         <= '0;
            iss_more_reg   <= 1'b0;
            dv_reg         <= 1'b0;
            d_last_reg     <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            start_reg      <= start_next;
            end_reg        <= end_next;
            noctr_reg      <= noctr_next;
            res_pend_reg   <= res_pend_next;
            read_reg       <= read_next;
            length_reg     <= length_next;
            nz_reg         <= nz_next;
            iss_more_reg   <= iss_more_next;
            dv_reg         <= dv_next;
            d_last_reg     <= d_last_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_fidx_reg   <= res_fidx_next;
        rd_addr_reg    <= rd_addr_next;
        rd_base_reg    <= rd_base_next;
        d_addr_reg     <= d_addr_next;
        d_base_reg     <= d_base_next;
        rsp_reg        <= rsp_next;
    end

    // Checks
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= XW'(CAPACITY))
        else $error("length above capacity");

    a_nz_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nz_reg <= NCW'(NW))
        else $error("nonzero word count above word count");

    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg != S_IDLE))
        else $error("accepted command did not start");

    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> ($past(state_reg) == S_DONE))
        else $error("response raised outside done state");

    a_dv_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> (state_reg == S_SCAN))
        else $error("word data pending outside scan");

endmodule
